// ===== hdl/matrix_inverse_3x3_unit_macros.svh =====
// assertion macros shared by the matrix inverse unit
`ifndef MATRIX_INVERSE_3X3_UNIT_MACROS_SVH
`define MATRIX_INVERSE_3X3_UNIT_MACROS_SVH
`ifndef SYNTH
// condition must never hold outside reset
`define MIV_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");
// antecedent implies consequent in the same cycle
`define MIV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");
`else
`define MIV_ASSERT_NEVER(label, clk, rst, cond)
`define MIV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/miv_pkg.sv =====
`timescale 1ns / 1ps
package miv_pkg;

   localparam int ENTRY_W     = 16;
   localparam int RESULT_W    = 32;
   localparam int NLANE       = 9;
   localparam int PROD_W      = 2 * ENTRY_W;
   localparam int COF_W       = PROD_W;
   localparam int DPROD_W     = ENTRY_W + COF_W;
   localparam int DET_W       = DPROD_W + 2;
   localparam int SCALE_SHIFT = 24;
   localparam int NUM_W       = COF_W + SCALE_SHIFT;
   localparam int DMAG_W      = DET_W;
   localparam int QUO_W       = RESULT_W;
   localparam int WIDE_W      = DMAG_W + QUO_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic signed [ENTRY_W-1:0] miv_entry_type;
   typedef miv_entry_type [NLANE-1:0] miv_mat_type;
   typedef logic signed [COF_W-1:0] miv_cof_type;
   typedef logic signed [RESULT_W-1:0] miv_result_type;

   // cofactors and determinant handed from front to back
   typedef struct packed {
      miv_cof_type [NLANE-1:0] cof;
      logic signed [DET_W-1:0] det;
   } miv_front_type;

   // one division lane in flight
   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [NUM_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
   } miv_lane_type;

   typedef struct packed {
      logic                   singular;
      logic [DMAG_W-1:0]      dmag;
      miv_lane_type [NLANE-1:0] lane;
   } miv_div_type;

endpackage

// ===== hdl/miv_front.sv =====
`timescale 1ns / 1ps
module miv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  miv_pkg::miv_mat_type mat_in,
   input  logic                 queue_full,
   output logic                 push,
   output miv_pkg::miv_front_type front_out
);
   import miv_pkg::*;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [PROD_W-1:0]  pa_ff [NLANE];
   logic signed [PROD_W-1:0]  pb_ff [NLANE];
   logic signed [ENTRY_W-1:0] r0a_ff [3];
   logic signed [ENTRY_W-1:0] r0b_ff [3];
   logic signed [COF_W-1:0]   cofa_ff [NLANE];
   logic signed [COF_W-1:0]   cofb_ff [NLANE];
   logic signed [COF_W-1:0]   cofc_ff [NLANE];
   logic signed [DPROD_W-1:0] dp_ff [3];
   logic signed [DET_W-1:0]   det_ff;

   // whole front advances unless its last stage is blocked by a full queue
   assign en        = !(v4_ff && queue_full);
   assign req_ready = en;
   assign push      = v4_ff && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // cofactor products, cofactor differences
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int N  = i * 3 + j;
         localparam int R1 = (i + 1) % 3;
         localparam int R2 = (i + 2) % 3;
         localparam int C1 = (j + 1) % 3;
         localparam int C2 = (j + 2) % 3;
         always_ff @(posedge clock) begin
            if (en) begin
               pa_ff[N]   <= $signed(mat_in[R1 * 3 + C1]) * $signed(mat_in[R2 * 3 + C2]);
               pb_ff[N]   <= $signed(mat_in[R1 * 3 + C2]) * $signed(mat_in[R2 * 3 + C1]);
               cofa_ff[N] <= COF_W'(pa_ff[N] - pb_ff[N]);
               cofb_ff[N] <= cofa_ff[N];
               cofc_ff[N] <= cofb_ff[N];
            end
         end
      end
   end

   // first row carried along, determinant terms and sum
   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (en) begin
            r0a_ff[j] <= $signed(mat_in[j]);
            r0b_ff[j] <= r0a_ff[j];
            dp_ff[j]  <= DPROD_W'(r0b_ff[j]) * DPROD_W'(cofa_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= DET_W'(dp_ff[0]) + DET_W'(dp_ff[1]) + DET_W'(dp_ff[2]);
      end
   end

   always_comb begin
      for (int n = 0; n < NLANE; n++) begin
         front_out.cof[n] = cofc_ff[n];
      end
      front_out.det = det_ff;
   end

endmodule

// ===== hdl/miv_queue.sv =====
`timescale 1ns / 1ps
module miv_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  miv_pkg::miv_front_type push_data,
   input  logic                   pop,
   output miv_pkg::miv_front_type pop_data,
   output logic                   full,
   output logic                   empty
);
   import miv_pkg::*;
   `include "matrix_inverse_3x3_unit_macros.svh"

   miv_front_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `MIV_ASSERT_NEVER(a_no_push_full, clock, reset, push && full)
   `MIV_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && empty)
   `MIV_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > (QPTR_W+1)'(QUEUE_DEPTH))
   `MIV_ASSERT_IMPLIES(a_ptr_match, clock, reset, empty, wr_ptr_ff == rd_ptr_ff)

endmodule

// ===== hdl/miv_divider.sv =====
`timescale 1ns / 1ps
module miv_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  miv_pkg::miv_front_type q_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output miv_pkg::miv_result_type inv [miv_pkg::NLANE],
   output logic                   singular
);
   import miv_pkg::*;

   localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_MAG = {1'b1, {(QUO_W-1){1'b0}}};

   logic          en;
   logic          vld_ff [QUO_W+1];
   miv_div_type   div_ff [QUO_W+1];
   miv_div_type   div_in [QUO_W+1];
   logic          rsp_valid_ff;
   miv_result_type inv_ff [NLANE];
   logic          singular_ff;

   // back pipeline stalls only while a result waits at the output
   assign en        = !(rsp_valid_ff && !rsp_ready);
   assign pop       = en && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign singular  = singular_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_W; s++) vld_ff[s] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= q_valid;
         for (int s = 1; s <= QUO_W; s++) vld_ff[s] <= vld_ff[s-1];
         rsp_valid_ff <= vld_ff[QUO_W];
      end
   end

   // load: magnitudes, result sign, overflow precheck
   always_comb begin
      logic [DET_W-1:0] dm;
      logic [COF_W-1:0] cm;
      logic [NUM_W-1:0] nm;
      dm = q_data.det[DET_W-1] ? DET_W'(-q_data.det) : DET_W'(q_data.det);
      div_in[0].singular = (q_data.det == '0);
      div_in[0].dmag     = dm;
      for (int n = 0; n < NLANE; n++) begin
         cm = q_data.cof[n][COF_W-1] ? (~q_data.cof[n] + 1'b1) : q_data.cof[n];
         nm = {cm, {SCALE_SHIFT{1'b0}}};
         div_in[0].lane[n].neg = q_data.cof[n][COF_W-1] ^ q_data.det[DET_W-1];
         div_in[0].lane[n].ovf = (WIDE_W'(nm) >= {dm, {QUO_W{1'b0}}});
         div_in[0].lane[n].rem = nm;
         div_in[0].lane[n].quo = '0;
      end
   end

   // one restoring quotient bit per stage, most significant first
   for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
      localparam int K = QUO_W - s;
      always_comb begin
         logic [WIDE_W-1:0] trial;
         logic [WIDE_W-1:0] remw;
         div_in[s] = div_ff[s-1];
         trial = WIDE_W'(div_ff[s-1].dmag) << K;
         for (int n = 0; n < NLANE; n++) begin
            remw = WIDE_W'(div_ff[s-1].lane[n].rem);
            if (remw >= trial) begin
               div_in[s].lane[n].rem    = NUM_W'(remw - trial);
               div_in[s].lane[n].quo[K] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= QUO_W; s++) div_ff[s] <= div_in[s];
      end
   end

   // sign, saturation and transpose into the output register
   always_ff @(posedge clock) begin
      if (en) begin
         singular_ff <= div_ff[QUO_W].singular;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (div_ff[QUO_W].singular) begin
                  inv_ff[j*3+i] <= '0;
               end else if (div_ff[QUO_W].lane[i*3+j].neg) begin
                  if (div_ff[QUO_W].lane[i*3+j].ovf ||
                      div_ff[QUO_W].lane[i*3+j].quo > NEG_MAG) begin
                     inv_ff[j*3+i] <= RESULT_W'(NEG_MAG);
                  end else begin
                     inv_ff[j*3+i] <= RESULT_W'(-div_ff[QUO_W].lane[i*3+j].quo);
                  end
               end else begin
                  if (div_ff[QUO_W].lane[i*3+j].ovf ||
                      div_ff[QUO_W].lane[i*3+j].quo > POS_MAX) begin
                     inv_ff[j*3+i] <= RESULT_W'(POS_MAX);
                  end else begin
                     inv_ff[j*3+i] <= RESULT_W'(div_ff[QUO_W].lane[i*3+j].quo);
                  end
               end
            end
         end
      end
   end

   assign inv = inv_ff;

endmodule

// ===== hdl/matrix_inverse_3x3_unit.sv =====
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate method: takes one signed Q8.8 matrix per
// transaction and returns its inverse in signed Q16.16, truncated toward zero
// and saturated, with rsp_singular set and all entries zero when the
// determinant is zero. One matrix is accepted every cycle unless req_ready is
// low because the front is blocked by a full queue; a result passes through 39
// register stages counting the one loaded at acceptance: 4 front stages forming
// cofactors and determinant, one queue slot, 33 stages of the bit-per-stage
// divider, one output register. The divider depth is set by its 32 quotient
// bits; a 4-entry queue between the cofactor front and the divider lets each
// side stall independently.
module matrix_inverse_3x3_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  miv_pkg::miv_entry_type  req_a00,
   input  miv_pkg::miv_entry_type  req_a01,
   input  miv_pkg::miv_entry_type  req_a02,
   input  miv_pkg::miv_entry_type  req_a10,
   input  miv_pkg::miv_entry_type  req_a11,
   input  miv_pkg::miv_entry_type  req_a12,
   input  miv_pkg::miv_entry_type  req_a20,
   input  miv_pkg::miv_entry_type  req_a21,
   input  miv_pkg::miv_entry_type  req_a22,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output miv_pkg::miv_result_type rsp_inv00,
   output miv_pkg::miv_result_type rsp_inv01,
   output miv_pkg::miv_result_type rsp_inv02,
   output miv_pkg::miv_result_type rsp_inv10,
   output miv_pkg::miv_result_type rsp_inv11,
   output miv_pkg::miv_result_type rsp_inv12,
   output miv_pkg::miv_result_type rsp_inv20,
   output miv_pkg::miv_result_type rsp_inv21,
   output miv_pkg::miv_result_type rsp_inv22,
   output logic                    rsp_singular
);
   import miv_pkg::*;

   miv_mat_type    mat;
   miv_front_type  front_data, queue_data;
   logic           push, pop, full, empty;
   miv_result_type inv [NLANE];

   // matrix entries in row-major order
   assign mat[0] = req_a00;
   assign mat[1] = req_a01;
   assign mat[2] = req_a02;
   assign mat[3] = req_a10;
   assign mat[4] = req_a11;
   assign mat[5] = req_a12;
   assign mat[6] = req_a20;
   assign mat[7] = req_a21;
   assign mat[8] = req_a22;

   miv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .mat_in     (mat),
      .queue_full (full),
      .push       (push),
      .front_out  (front_data)
   );

   miv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_data),
      .pop       (pop),
      .pop_data  (queue_data),
      .full      (full),
      .empty     (empty)
   );

   miv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!empty),
      .q_data    (queue_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .inv       (inv),
      .singular  (rsp_singular)
   );

   assign rsp_inv00 = inv[0];
   assign rsp_inv01 = inv[1];
   assign rsp_inv02 = inv[2];
   assign rsp_inv10 = inv[3];
   assign rsp_inv11 = inv[4];
   assign rsp_inv12 = inv[5];
   assign rsp_inv20 = inv[6];
   assign rsp_inv21 = inv[7];
   assign rsp_inv22 = inv[8];

endmodule
